### sv/tfr_pkg.sv
// Package: shared constants, status codes and helpers for the threshold frame receiver.
`default_nettype none
package tfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int VAL_W    = 7;
	localparam int DIGIT_W  = 4;
	localparam int CNT_W    = 3;
	localparam int NDIGITS  = 4;
	localparam int STATUS_W = 3;
	localparam int PADDR_W  = 3;
	localparam int PDATA_W  = 32;

	localparam logic [BYTE_W-1:0] START_CHAR = 8'h3C;
	localparam logic [BYTE_W-1:0] END_CHAR   = 8'h3E;
	localparam logic [BYTE_W-1:0] ZERO_CHAR  = 8'h30;
	localparam logic [BYTE_W-1:0] NINE_CHAR  = 8'h39;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(NDIGITS);

	localparam logic [VAL_W-1:0] LOWER_RESET = 7'd50;
	localparam logic [VAL_W-1:0] UPPER_RESET = 7'd90;

	// register byte addresses
	localparam logic [PADDR_W-1:0] ADDR_LOWER = 3'd0;
	localparam logic [PADDR_W-1:0] ADDR_UPPER = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_NONE     = 3'd0,
		ST_ACCEPTED = 3'd1,
		ST_COUNT    = 3'd2,
		ST_ORDER    = 3'd3,
		ST_RANGE    = 3'd4,
		ST_ABORT    = 3'd5
	} status_t;

	// two decimal digits to a binary value: tens*8 + tens*2 + units
	function automatic logic [VAL_W-1:0] dec2(input logic [DIGIT_W-1:0] tens,
		input logic [DIGIT_W-1:0] units);
		logic [VAL_W-1:0] t;
		logic [VAL_W-1:0] u;
		t = VAL_W'(tens);
		u = VAL_W'(units);
		return (t << 3) + (t << 1) + u;
	endfunction

endpackage
`default_nettype wire

### sv/tfr_if.sv
// Interfaces: received-byte channel and result channel.
`default_nettype none
interface tfr_rx_if;
	import tfr_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source(output valid, output rx_byte, input ready);
	modport sink(input valid, input rx_byte, output ready);
endinterface

interface tfr_res_if;
	import tfr_pkg::*;
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] frame_status;
	logic                remote_on;
	logic [VAL_W-1:0]    low_value;
	logic [VAL_W-1:0]    high_value;

	modport source(output valid, output frame_status, output remote_on,
		output low_value, output high_value, input ready);
	modport sink(input valid, input frame_status, input remote_on,
		input low_value, input high_value, output ready);
endinterface
`default_nettype wire

### sv/threshold_frame_receiver.sv
// Top level: parser for '<dddd>' threshold frames with an APB limit register port.
//
// Usage
//  rx     : one received ASCII byte per item (valid/ready). '<' opens a frame,
//           four digits give low (first two) and high (last two), '>' closes it.
//  result : one item per received byte: frame_status (0 none, 1 accepted,
//           2 wrong digit count, 3 high below low, 4 out of range, 5 aborted),
//           plus remote_on, low_value and high_value as they stand after it.
//  apb    : lower_limit at 0x0, upper_limit at 0x4 (7 bits each), readable,
//           pready tied high; user writes only with no item in flight, unchecked.
// Timing
//  One byte an item, accepted every cycle while rx.ready is high. Each byte
//  passes through an input register, then the parse and compare logic into
//  the result register.
// Reset
//  arst_n clears frame state, the sticky flag and the kept pair; limits go
//  to 50 and 90. Stored digits are not cleared; they are only read once
//  all four were written in the current frame.
// Stalls
//  With result.ready low the result is held; one more byte sits in the input
//  register, after which rx.ready drops.
`default_nettype none
module threshold_frame_receiver (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [tfr_pkg::PADDR_W-1:0]   paddr,
	input  wire [tfr_pkg::PDATA_W-1:0]   pwdata,
	output logic [tfr_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready,
	tfr_rx_if.sink                       rx,
	tfr_res_if.source                    result
);
	import tfr_pkg::*;

	// configuration
	logic [VAL_W-1:0] lower_q, upper_q;

	// input stage
	logic              v_s1;
	logic [BYTE_W-1:0] byte_s1;

	// frame state
	logic                frame_open_q;
	logic [CNT_W-1:0]    count_q;
	logic [DIGIT_W-1:0]  digit_q [NDIGITS];
	logic                remote_q;
	logic [VAL_W-1:0]    low_q, high_q;

	// result register
	logic    res_v_q;
	status_t status_q;

	logic    adv;
	logic    is_digit;
	logic [VAL_W-1:0] lo, hi;
	status_t pair_st, status_d;
	logic    store_digit, close_frame, keep_pair;

	// ---------------- APB ----------------
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_q <= LOWER_RESET;
			upper_q <= UPPER_RESET;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_LOWER) begin
				lower_q <= pwdata[VAL_W-1:0];
			end else if (paddr == ADDR_UPPER) begin
				upper_q <= pwdata[VAL_W-1:0];
			end
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == ADDR_LOWER) begin
			prdata = PDATA_W'(lower_q);
		end else if (paddr == ADDR_UPPER) begin
			prdata = PDATA_W'(upper_q);
		end
	end

	// ---------------- handshake ----------------
	// item moves from the input register into the result register
	assign adv      = v_s1 && (!res_v_q || result.ready);
	assign rx.ready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rx.ready) begin
			v_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// ---------------- parse ----------------
	assign is_digit = (byte_s1 >= ZERO_CHAR) && (byte_s1 <= NINE_CHAR);
	assign lo = dec2(digit_q[0], digit_q[1]);
	assign hi = dec2(digit_q[2], digit_q[3]);

	always_comb begin
		if (hi < lo) begin
			pair_st = ST_ORDER;
		end else if (lo < lower_q || lo > upper_q || hi < lower_q || hi > upper_q) begin
			pair_st = ST_RANGE;
		end else begin
			pair_st = ST_ACCEPTED;
		end
	end

	always_comb begin
		status_d    = ST_NONE;
		store_digit = 1'b0;
		close_frame = 1'b0;
		keep_pair   = 1'b0;
		if (byte_s1 != START_CHAR && frame_open_q) begin
			if (is_digit) begin
				if (count_q < FULL_COUNT) begin
					store_digit = 1'b1;
				end else begin
					close_frame = 1'b1;
					status_d    = ST_ABORT;
				end
			end else if (byte_s1 == END_CHAR) begin
				close_frame = 1'b1;
				if (count_q == FULL_COUNT) begin
					status_d  = pair_st;
					keep_pair = (pair_st == ST_ACCEPTED);
				end else begin
					status_d = ST_COUNT;
				end
			end else begin
				close_frame = 1'b1;
				status_d    = ST_ABORT;
			end
		end
	end

	// frame state advances with each item as it reaches the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_open_q <= 1'b0;
			count_q      <= '0;
			remote_q     <= 1'b0;
			low_q        <= '0;
			high_q       <= '0;
		end else if (adv) begin
			if (byte_s1 == START_CHAR) begin
				frame_open_q <= 1'b1;
				count_q      <= '0;
			end else if (close_frame) begin
				frame_open_q <= 1'b0;
				count_q      <= '0;
			end else if (store_digit) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (keep_pair) begin
				remote_q <= 1'b1;
				low_q    <= lo;
				high_q   <= hi;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store_digit) begin
			digit_q[count_q[1:0]] <= byte_s1[DIGIT_W-1:0];
		end
	end

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			status_q <= ST_NONE;
		end else if (adv) begin
			res_v_q  <= 1'b1;
			status_q <= status_d;
		end else if (result.ready) begin
			res_v_q <= 1'b0;
		end
	end

	// kept pair and flag only change when a new item enters the result
	// register, so they always belong to the item on show
	assign result.valid        = res_v_q;
	assign result.frame_status = status_q;
	assign result.remote_on    = remote_q;
	assign result.low_value    = low_q;
	assign result.high_value   = high_q;

endmodule
`default_nettype wire

### sv/tfr_checker.sv
// Checker on the top-level ports of the threshold frame receiver, with its bind.
`default_nettype none
module tfr_checker (
	input wire                          clk,
	input wire                          arst_n,
	input wire                          pready,
	input wire                          res_valid,
	input wire                          res_ready,
	input wire [tfr_pkg::STATUS_W-1:0]  frame_status,
	input wire                          remote_on,
	input wire [tfr_pkg::VAL_W-1:0]     low_value,
	input wire [tfr_pkg::VAL_W-1:0]     high_value
);
	import tfr_pkg::*;

	// held result keeps its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(frame_status)
		&& $stable(remote_on) && $stable(low_value) && $stable(high_value))
		else $error("result changed while stalled");

	// the remote flag never falls once shown
	a_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && remote_on |=> !res_valid || remote_on)
		else $error("remote flag dropped");

	// an accepted frame raises the flag and shows an ordered pair
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && frame_status == ST_ACCEPTED |->
		remote_on && (low_value <= high_value))
		else $error("accepted frame without flag or ordered pair");

	// without the flag nothing was ever kept
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !remote_on |-> low_value == '0 && high_value == '0)
		else $error("pair kept without remote flag");

	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind threshold_frame_receiver tfr_checker u_tfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.pready       (pready),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.frame_status (result.frame_status),
	.remote_on    (result.remote_on),
	.low_value    (result.low_value),
	.high_value   (result.high_value)
);
`default_nettype wire

### sim/tb_top.sv
// Testbench for threshold_frame_receiver: framed byte stimulus, result prediction and checking.
`timescale 1ns / 100ps
module tb_top;
	import tfr_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 6;
	localparam int PHASES       = 7;
	localparam int PHASE_ITEMS  = 220;
	localparam int SETTLE       = 8;       // idle wait that lets the input and result registers empty
	localparam int LIMIT_CYCLES = 200000;  // far beyond the slowest stalled run

	// one predicted result item
	typedef struct packed {
		status_t          status;
		logic             remote;
		logic [VAL_W-1:0] lo;
		logic [VAL_W-1:0] hi;
	} frame_res_t;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	tfr_rx_if  rx_ch();
	tfr_res_if res_ch();

	threshold_frame_receiver uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.rx      (rx_ch),
		.result  (res_ch)
	);

	// bytes waiting to be sent, and results predicted but not yet seen
	logic [BYTE_W-1:0] rx_bytes_q[$];
	frame_res_t        frame_res_q[$];

	int queued_cnt;
	int accepted_cnt;
	int result_cnt;
	int fail_cnt;
	int cycle_cnt;
	int status_hits[6];
	int send_gap_pct;
	int recv_stall_pct;

	// predictor state: a private copy of the parser and the limit registers
	logic                 frame_open;
	logic [CNT_W-1:0]     digit_cnt;
	logic [DIGIT_W-1:0]   digit_q[NDIGITS];
	logic                 remote_flag;
	logic [VAL_W-1:0]     kept_lo;
	logic [VAL_W-1:0]     kept_hi;
	logic [VAL_W-1:0]     lim_lo;
	logic [VAL_W-1:0]     lim_hi;

	always #HALF_PERIOD clk = ~clk;

	// Parse one accepted byte and return the result item it must produce.
	// Stored digits are only ever read once all four came in the current
	// frame, so their reset value never matters.
	function automatic frame_res_t parse_byte(input logic [BYTE_W-1:0] c);
		frame_res_t r;
		int lo_v;
		int hi_v;
		r.status = ST_NONE;
		if (c == START_CHAR) begin
			// '<' restarts, open frame or not
			frame_open = 1'b1;
			digit_cnt  = '0;
		end else if (frame_open) begin
			if (c >= ZERO_CHAR && c <= NINE_CHAR) begin
				if (digit_cnt < FULL_COUNT) begin
					digit_q[digit_cnt[1:0]] = DIGIT_W'(c - ZERO_CHAR);
					digit_cnt = digit_cnt + 1'b1;
				end else begin
					// one digit too many
					frame_open = 1'b0;
					digit_cnt  = '0;
					r.status   = ST_ABORT;
				end
			end else if (c == END_CHAR) begin
				if (digit_cnt != FULL_COUNT) begin
					r.status = ST_COUNT;
				end else begin
					lo_v = int'(digit_q[0]) * 10 + int'(digit_q[1]);
					hi_v = int'(digit_q[2]) * 10 + int'(digit_q[3]);
					if (hi_v < lo_v) begin
						r.status = ST_ORDER;
					end else if (lo_v < int'(lim_lo) || lo_v > int'(lim_hi) ||
						hi_v < int'(lim_lo) || hi_v > int'(lim_hi)) begin
						// also catches lower limit above upper limit
						r.status = ST_RANGE;
					end else begin
						r.status    = ST_ACCEPTED;
						remote_flag = 1'b1;
						kept_lo     = VAL_W'(lo_v);
						kept_hi     = VAL_W'(hi_v);
					end
				end
				frame_open = 1'b0;
				digit_cnt  = '0;
			end else begin
				// stray character inside a frame
				frame_open = 1'b0;
				digit_cnt  = '0;
				r.status   = ST_ABORT;
			end
		end
		// flag and pair always reflect the state after the byte
		r.remote = remote_flag;
		r.lo     = kept_lo;
		r.hi     = kept_hi;
		return r;
	endfunction

	// ---------------------------------------------------------------
	// Driver: offers queued bytes, with random gaps between items.
	// valid gets one nonblocking write per edge at most; a byte that is
	// offered but not yet taken is held untouched.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : rx_driver
		logic taken;
		if (arst_n) begin
			taken = rx_ch.valid && rx_ch.ready;
			if (taken) begin
				frame_res_q.push_back(parse_byte(rx_ch.rx_byte));
				accepted_cnt++;
			end
			if (!rx_ch.valid || taken) begin
				if (rx_bytes_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
					rx_ch.rx_byte <= rx_bytes_q.pop_front();
					rx_ch.valid   <= 1'b1;
				end else begin
					rx_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Monitor: random back-pressure, and each result taken is checked
	// field by field against the oldest prediction.
	// ---------------------------------------------------------------
	always @(posedge clk) begin : res_monitor
		frame_res_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				result_cnt++;
				if (frame_res_q.size() == 0) begin
					$error("unexpected result item: status %0d remote %0d low %0d high %0d",
						res_ch.frame_status, res_ch.remote_on, res_ch.low_value,
						res_ch.high_value);
					fail_cnt++;
				end else begin
					want = frame_res_q.pop_front();
					status_hits[want.status]++;
					if (res_ch.frame_status !== want.status) begin
						$error("frame_status: expected %0d, got %0d", want.status,
							res_ch.frame_status);
						fail_cnt++;
					end
					if (res_ch.remote_on !== want.remote) begin
						$error("remote_on: expected %0d, got %0d", want.remote,
							res_ch.remote_on);
						fail_cnt++;
					end
					if (res_ch.low_value !== want.lo) begin
						$error("low_value: expected %0d, got %0d", want.lo,
							res_ch.low_value);
						fail_cnt++;
					end
					if (res_ch.high_value !== want.hi) begin
						$error("high_value: expected %0d, got %0d", want.hi,
							res_ch.high_value);
						fail_cnt++;
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > LIMIT_CYCLES) begin
			$display("threshold_frame_receiver regression: fail");
			$finish;
		end
	end

	function automatic void push_byte(input logic [BYTE_W-1:0] b);
		rx_bytes_q.push_back(b);
		queued_cnt++;
	endfunction

	function automatic void push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_byte(s[i]);
	endfunction

	function automatic void push_digit(input int d);
		push_byte(ZERO_CHAR + BYTE_W'(d));
	endfunction

	function automatic int clip99(input int v);
		return (v < 0) ? 0 : (v > 99) ? 99 : v;
	endfunction

	// threshold values biased towards the current limits
	function automatic int pick_value();
		int v;
		case ($urandom_range(3))
			0: v = $urandom_range(99);
			1: v = int'(lim_lo) + $urandom_range(4) - 2;
			2: v = int'(lim_hi) + $urandom_range(4) - 2;
			default: v = $urandom_range(clip99(int'(lim_hi)), clip99(int'(lim_lo)));
		endcase
		return clip99(v);
	endfunction

	// one random sequence: mostly well-formed frames, the rest broken or noise
	function automatic void gen_frame();
		int kind;
		int n;
		int lo_v;
		int hi_v;
		int t;
		kind = $urandom_range(99);
		if (kind < 12) begin
			// line noise, any byte value
			n = $urandom_range(4, 1);
			repeat (n) push_byte(BYTE_W'($urandom_range(255)));
		end else if (kind < 22) begin
			// closed early
			push_byte(START_CHAR);
			n = $urandom_range(3);
			repeat (n) push_digit($urandom_range(9));
			push_byte(END_CHAR);
		end else if (kind < 30) begin
			// too many digits
			push_byte(START_CHAR);
			n = $urandom_range(6, 5);
			repeat (n) push_digit($urandom_range(9));
			if ($urandom_range(1)) push_byte(END_CHAR);
		end else if (kind < 38) begin
			// stray character mid-frame
			push_byte(START_CHAR);
			n = $urandom_range(4);
			repeat (n) push_digit($urandom_range(9));
			do t = $urandom_range(255);
			while ((t >= int'(ZERO_CHAR) && t <= int'(NINE_CHAR)) ||
				t == int'(START_CHAR) || t == int'(END_CHAR));
			push_byte(BYTE_W'(t));
		end else begin
			// full frame, now and then after an abandoned start
			if ($urandom_range(7) == 0) begin
				push_byte(START_CHAR);
				n = $urandom_range(4);
				repeat (n) push_digit($urandom_range(9));
			end
			lo_v = pick_value();
			hi_v = pick_value();
			if ($urandom_range(3) != 0 && hi_v < lo_v) begin
				t = lo_v; lo_v = hi_v; hi_v = t;
			end
			push_byte(START_CHAR);
			push_digit(lo_v / 10);
			push_digit(lo_v % 10);
			push_digit(hi_v / 10);
			push_digit(hi_v % 10);
			push_byte(END_CHAR);
		end
	endfunction

	function automatic void gen_items(input int n);
		int target;
		target = queued_cnt + n;
		while (queued_cnt < target) gen_frame();
	endfunction

	// every queued byte taken and every predicted result seen
	task automatic wait_drained();
		while (accepted_cnt != queued_cnt || frame_res_q.size() != 0) @(posedge clk);
	endtask

	// APB write with setup and access phases; upper data bits are junk, only seven are kept
	task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [VAL_W-1:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= (PDATA_W'($urandom) & ~PDATA_W'(7'h7F)) | PDATA_W'(val);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_limits(input logic [VAL_W-1:0] lo, input logic [VAL_W-1:0] hi);
		apb_write(ADDR_LOWER, lo);
		apb_write(ADDR_UPPER, hi);
		lim_lo = lo;
		lim_hi = hi;
	endtask

	initial begin : main_seq
		int a;
		int b;
		clk            = 1'b0;
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		rx_ch.valid    = 1'b0;
		rx_ch.rx_byte  = '0;
		res_ch.ready   = 1'b0;
		queued_cnt     = 0;
		accepted_cnt   = 0;
		result_cnt     = 0;
		fail_cnt       = 0;
		cycle_cnt      = 0;
		send_gap_pct   = 23;
		recv_stall_pct = 51;
		foreach (status_hits[i]) status_hits[i] = 0;
		frame_open  = 1'b0;
		digit_cnt   = '0;
		foreach (digit_q[i]) digit_q[i] = '0;
		remote_flag = 1'b0;
		kept_lo     = '0;
		kept_hi     = '0;
		lim_lo      = LOWER_RESET;
		lim_hi      = UPPER_RESET;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed cases at the reset limits of 50 and 90
		push_text("<5090>");     // both values on the limits: accepted
		push_text("<1<8050>");   // restart mid-frame, then high below low
		push_text("<4991>");     // both just outside the limits
		push_text("<>");         // no digits at all
		push_byte(START_CHAR);
		push_byte(8'h00);        // stray byte aborts
		push_text("<00000");     // fifth digit aborts
		push_byte(8'hFF);        // ignored outside a frame
		wait_drained();

		for (int p = 0; p < PHASES; p++) begin
			// idle pattern: sender-light first, then receiver-light, then none
			if (p < 2) begin
				send_gap_pct = 23; recv_stall_pct = 51;
			end else if (p < 4) begin
				send_gap_pct = 51; recv_stall_pct = 23;
			end else begin
				send_gap_pct = 0;  recv_stall_pct = 0;
			end
			if (p > 0) begin
				// idle block: let the pipeline empty before touching limits
				repeat (SETTLE) @(posedge clk);
				case (p)
					1: set_limits(7'd0, 7'd99);
					2: set_limits(7'd99, 7'd99);
					3: set_limits(7'd127, 7'd0);   // lower above upper: all rejected
					4: set_limits(7'd0, 7'd0);
					5: set_limits(7'd0, 7'd127);
					default: begin
						a = $urandom_range(99);
						b = $urandom_range(99);
						if (a <= b) set_limits(VAL_W'(a), VAL_W'(b));
						else set_limits(VAL_W'(b), VAL_W'(a));
					end
				endcase
			end
			// two halves with a full drain between: sender holds off until
			// every result is back
			gen_items(PHASE_ITEMS / 2);
			wait_drained();
			gen_items(PHASE_ITEMS / 2);
			wait_drained();
		end

		repeat (SETTLE) @(posedge clk);
		$display("Sent %0d bytes over %0d limit settings and three idle patterns; %0d results.",
			accepted_cnt, PHASES, result_cnt);
		$display("Results: none %0d, accepted %0d, count %0d, order %0d, range %0d, abort %0d.",
			status_hits[ST_NONE], status_hits[ST_ACCEPTED], status_hits[ST_COUNT],
			status_hits[ST_ORDER], status_hits[ST_RANGE], status_hits[ST_ABORT]);
		if (fail_cnt == 0 && frame_res_q.size() == 0) begin
			$display("threshold_frame_receiver regression: pass");
		end else begin
			$display("threshold_frame_receiver regression: fail");
		end
		$finish;
	end

endmodule
